FILE: design/csmatx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA-CA transmit controller package
// Shared types, codes and register reset values of the transmit controller.
// ----------------------------------------------------------------------------
package csmatx_pkg;

   // Configuration register reset values.
   localparam logic [3:0]  MinBackoffExpReset   = 4'd3;
   localparam logic [3:0]  MaxBackoffExpReset   = 4'd5;
   localparam logic [2:0]  MaxBackoffsReset     = 3'd4;
   localparam logic [3:0]  MaxTransmissionsReset = 4'd3;
   localparam logic [15:0] UnitBackoffUsReset   = 16'd320;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_MIN_BACKOFF_EXP   = 3'd0,
      CSR_MAX_BACKOFF_EXP   = 3'd1,
      CSR_MAX_BACKOFFS      = 3'd2,
      CSR_MAX_TRANSMISSIONS = 3'd3,
      CSR_UNIT_BACKOFF_US   = 3'd4
   } csr_index_type;

   // Event kinds on the request channel.
   typedef enum logic [1:0] {
      REQ_START     = 2'd0,
      REQ_CCA       = 2'd1,
      REQ_TX_RESULT = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CCA_FREE    = 2'd0,
      CCA_BUSY    = 2'd1,
      CCA_RX_BUSY = 2'd2
   } cca_code_type;

   typedef enum logic [1:0] {
      TX_OK     = 2'd0,
      TX_NO_ACK = 2'd1,
      TX_ERROR  = 2'd2
   } tx_code_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_BACKOFF = 2'd1,
      ACT_SEND    = 2'd2,
      ACT_DONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_ACK     = 3'd1,
      ST_CH_BUSY    = 3'd2,
      ST_RADIO_BUSY = 3'd3,
      ST_TX_ERROR   = 3'd4
   } status_type;

   // Transfer phase, one-hot.
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_CCA  = 3'b010,
      PH_TX   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [3:0]  min_backoff_exp;
      logic [3:0]  max_backoff_exp;
      logic [2:0]  max_backoffs;
      logic [3:0]  max_transmissions;
      logic [15:0] unit_backoff_us;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       ack_request;
      logic [7:0] rand_value;
      logic [1:0] cca_status;
      logic [1:0] tx_status;
   } req_item_type;

   typedef struct packed {
      action_type  action;
      logic [23:0] backoff_us;
      status_type  final_status;
      logic [3:0]  retries_used;
   } rsp_item_type;

endpackage
`default_nettype wire

FILE: design/csma_ca_transmit_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA-CA transmit controller
// Unslotted CSMA-CA with retransmission, driven by radio and software events.
// ----------------------------------------------------------------------------
// Usage. Events enter on the req_ channel: a start request, a CCA result or a
// radio transmit result, with the kind in req_tuser. Every accepted event gives
// exactly one item on the rsp_ channel, whose kind (none, back off then CCA,
// transmit, finished) is in rsp_tuser. Events that do not fit the current
// phase of the transfer give the action none and change nothing.
// From acceptance, an event passes the input register and then the result
// register before its result can be taken. The block takes one event every
// cycle while the receiver takes results; the state machine decides and
// updates its state in one pass.
// When the receiver stalls, the result register holds its item and the input
// register takes one more event, after which req_tready falls until the
// result is taken. Configuration writes on the csr_ channel are always taken
// and apply at once; they should be made only while the block is idle.
// Reset is synchronous: it empties both registers, returns the transfer to
// idle and loads the default limits (exponents 3 and 5, four backoffs,
// three transmissions, a unit backoff of 320 us).
// ----------------------------------------------------------------------------
module csma_ca_transmit_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // ack_request, rand_value[7:0],
                                        // cca_status[1:0], tx_status[1:0], zeros
   input  wire logic [1:0]  req_tuser,  // req_type[1:0]
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // backoff_us[23:0], final_status[2:0],
                                        // retries_used[3:0], zero
   output logic [1:0]       rsp_tuser,  // action[1:0]
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import csmatx_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff, in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type fsm_result;
   rsp_item_type rsp_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         req_accept;

   csmatx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held event moves on whenever the result register is free or drains.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_item_in.req_type     = req_tuser;
      in_item_in.ack_request  = req_tdata[0];
      in_item_in.rand_value   = req_tdata[8:1];
      in_item_in.cca_status   = req_tdata[10:9];
      in_item_in.tx_status    = req_tdata[12:11];
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   csmatx_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (fsm_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         rsp_item_ff <= fsm_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.action;
   assign rsp_tdata  = {1'b0, rsp_item_ff.retries_used, rsp_item_ff.final_status,
                        rsp_item_ff.backoff_us};

endmodule
`default_nettype wire

FILE: design/csmatx_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA-CA configuration registers
// Holds the backoff and retransmission limits written over the CSR channel.
// ----------------------------------------------------------------------------
module csmatx_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [2:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   output csmatx_pkg::cfg_type       cfg
);
   import csmatx_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken at once.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_BACKOFF_EXP:   cfg_in.min_backoff_exp   = csr_wdata[3:0];
            CSR_MAX_BACKOFF_EXP:   cfg_in.max_backoff_exp   = csr_wdata[3:0];
            CSR_MAX_BACKOFFS:      cfg_in.max_backoffs      = csr_wdata[2:0];
            CSR_MAX_TRANSMISSIONS: cfg_in.max_transmissions = csr_wdata[3:0];
            CSR_UNIT_BACKOFF_US:   cfg_in.unit_backoff_us   = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_backoff_exp   <= MinBackoffExpReset;
         cfg_ff.max_backoff_exp   <= MaxBackoffExpReset;
         cfg_ff.max_backoffs      <= MaxBackoffsReset;
         cfg_ff.max_transmissions <= MaxTransmissionsReset;
         cfg_ff.unit_backoff_us   <= UnitBackoffUsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/csmatx_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSMA-CA transfer state machine
// Holds the transfer state and works out the result of one event.
// ----------------------------------------------------------------------------
module csmatx_fsm (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire csmatx_pkg::req_item_type item,
   input  wire csmatx_pkg::cfg_type      cfg,
   output csmatx_pkg::rsp_item_type      result
);
   import csmatx_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [2:0] count_ff, count_in;
   logic [3:0] exp_ff, exp_in;
   logic [3:0] retry_ff, retry_in;
   logic       ack_wanted_ff, ack_wanted_in;

   logic [3:0] delay_exp;
   logic [7:0] mask;
   logic [23:0] delay;
   logic [3:0] next_count;
   logic [4:0] raised_exp;
   logic [3:0] capped_exp;
   logic [4:0] next_retry;
   logic [3:0] sat_retry;

   // Backoff delay: random byte masked to the exponent, times the unit period.
   assign mask  = (delay_exp >= 4'd8) ? 8'hFF : 8'((16'd1 << delay_exp) - 16'd1);
   assign delay = 24'(item.rand_value & mask) * 24'(cfg.unit_backoff_us);

   assign next_count = {1'b0, count_ff} + 4'd1;
   assign raised_exp = {1'b0, exp_ff} + 5'd1;
   assign capped_exp = (raised_exp > {1'b0, cfg.max_backoff_exp}) ?
                       cfg.max_backoff_exp : raised_exp[3:0];
   assign next_retry = {1'b0, retry_ff} + 5'd1;
   assign sat_retry  = (next_retry > 5'd15) ? 4'd15 : next_retry[3:0];

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      exp_in        = exp_ff;
      retry_in      = retry_ff;
      ack_wanted_in = ack_wanted_ff;
      delay_exp     = cfg.min_backoff_exp;
      result.action       = ACT_NONE;
      result.final_status = ST_OK;
      result.retries_used = 4'd0;

      priority if (item.req_type == REQ_START && phase_ff == PH_IDLE) begin
         ack_wanted_in = item.ack_request;
         retry_in      = 4'd0;
         count_in      = 3'd0;
         exp_in        = cfg.min_backoff_exp;
         phase_in      = PH_CCA;
         result.action = ACT_BACKOFF;
      end else if (item.req_type == REQ_CCA && phase_ff == PH_CCA) begin
         priority if (item.cca_status == CCA_FREE) begin
            phase_in      = PH_TX;
            result.action = ACT_SEND;
         end else if (item.cca_status == CCA_RX_BUSY) begin
            phase_in            = PH_IDLE;
            result.action       = ACT_DONE;
            result.final_status = ST_RADIO_BUSY;
            result.retries_used = retry_ff;
         end else begin
            // Busy channel, and the unused code: back off again, or finish once the backoff limit is passed.
            exp_in    = capped_exp;
            count_in  = next_count[2:0];
            delay_exp = capped_exp;
            if (next_count > {1'b0, cfg.max_backoffs}) begin
               phase_in            = PH_IDLE;
               result.action       = ACT_DONE;
               result.final_status = ST_CH_BUSY;
               result.retries_used = retry_ff;
            end else begin
               result.action = ACT_BACKOFF;
            end
         end
      end else if (item.req_type == REQ_TX_RESULT && phase_ff == PH_TX) begin
         priority if (item.tx_status == TX_OK) begin
            phase_in            = PH_IDLE;
            result.action       = ACT_DONE;
            result.final_status = ST_OK;
            result.retries_used = retry_ff;
         end else if (item.tx_status == TX_NO_ACK && ack_wanted_ff) begin
            retry_in = sat_retry;
            if (next_retry < {1'b0, cfg.max_transmissions}) begin
               count_in      = 3'd0;
               exp_in        = cfg.min_backoff_exp;
               phase_in      = PH_CCA;
               result.action = ACT_BACKOFF;
            end else begin
               phase_in            = PH_IDLE;
               result.action       = ACT_DONE;
               result.final_status = ST_NO_ACK;
               result.retries_used = sat_retry;
            end
         end else if (item.tx_status == TX_NO_ACK) begin
            phase_in            = PH_IDLE;
            result.action       = ACT_DONE;
            result.final_status = ST_NO_ACK;
            result.retries_used = retry_ff;
         end else begin
            phase_in            = PH_IDLE;
            result.action       = ACT_DONE;
            result.final_status = ST_TX_ERROR;
            result.retries_used = retry_ff;
         end
      end else begin
         // Out of phase events are ignored.
         result.action = ACT_NONE;
      end

      result.backoff_us = (result.action == ACT_BACKOFF) ? delay : 24'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= 3'd0;
         exp_ff        <= 4'd0;
         retry_ff      <= 4'd0;
         ack_wanted_ff <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         exp_ff        <= exp_in;
         retry_ff      <= retry_in;
         ack_wanted_ff <= ack_wanted_in;
      end
   end

endmodule
`default_nettype wire

FILE: test/csma_ca_transmit_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSMA-CA transmit controller testbench
// Drives start, CCA and transmit-result events into the controller, predicts
// each result item from a behavioural copy of the transfer state and compares
// every result item field by field, across several register settings.
// ----------------------------------------------------------------------------
module csma_ca_transmit_controller_tb;
   import csmatx_pkg::*;

   // Codes that the package leaves unnamed but that the fields can carry.
   localparam logic [1:0] REQ_RESERVED = 2'd3;
   localparam logic [1:0] CCA_UNKNOWN  = 2'd3;
   localparam logic [1:0] TX_UNKNOWN   = 2'd3;
   localparam logic [2:0] CSR_SPARE_LO = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   localparam int IDLE_PERCENT   = 35;
   localparam int RANDOM_ITEMS   = 824;
   localparam int SETTING_PHASES = 8;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 100;

   // Clock, reset and the block's inputs, all known from time zero.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_ready;

   csma_ca_transmit_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // One row of the directed part. Where typed is set, the expected result is
   // written into the row; otherwise it comes from the transfer predictor.
   typedef struct {
      req_item_type ev;
      logic         typed;
      rsp_item_type rsp;
   } event_row_type;

   event_row_type directed_rows[$];
   rsp_item_type  pending_responses[$];

   // Behavioural copy of the controller: registers and transfer state.
   cfg_type    cfg;
   phase_type  tx_phase;
   logic [2:0] busy_count;
   logic [3:0] cur_exp;
   logic [3:0] retries;
   logic       want_ack;

   // While calm is set neither side idles; that gives one long stretch of
   // back-to-back traffic in the middle of the run.
   logic calm = 1'b0;

   int mismatches     = 0;
   int prints         = 0;
   int events_sent    = 0;
   int results_seen   = 0;
   int idle_cycles    = 0;
   int status_count[5] = '{default: 0};

   // ------------------------------------------------------------------------
   // Transfer predictor
   // ------------------------------------------------------------------------

   // Random backoff: the random byte masked to 2^exp-1, times the unit
   // period. Exponents of eight and above leave the whole byte.
   function automatic logic [23:0] backoff_delay(input logic [7:0] rnd);
      logic [7:0]  mask;
      logic [23:0] masked;
      mask   = (cur_exp >= 4'd8) ? 8'hFF : (8'hFF >> (4'd8 - cur_exp));
      masked = {16'd0, rnd & mask};
      return masked * {8'd0, cfg.unit_backoff_us};
   endfunction

   task automatic start_attempt(input logic [7:0] rnd, inout rsp_item_type r);
      busy_count   = '0;
      cur_exp      = cfg.min_backoff_exp;
      tx_phase     = PH_CCA;
      r.action     = ACT_BACKOFF;
      r.backoff_us = backoff_delay(rnd);
   endtask

   task automatic close_transfer(input status_type st, inout rsp_item_type r);
      tx_phase       = PH_IDLE;
      r.action       = ACT_DONE;
      r.final_status = st;
      r.retries_used = retries;
   endtask

   // Works out the result item of one accepted event and moves the state on.
   // Events that do not fit the phase leave everything as it is.
   task automatic predict_response(input req_item_type ev, output rsp_item_type r);
      logic [3:0] nb;
      logic [4:0] be;
      logic [4:0] nr;
      r = '0;
      if (ev.req_type == REQ_START && tx_phase == PH_IDLE) begin
         want_ack = ev.ack_request;
         retries  = '0;
         start_attempt(ev.rand_value, r);
      end else if (ev.req_type == REQ_CCA && tx_phase == PH_CCA) begin
         if (ev.cca_status == CCA_FREE) begin
            tx_phase = PH_TX;
            r.action = ACT_SEND;
         end else if (ev.cca_status == CCA_RX_BUSY) begin
            close_transfer(ST_RADIO_BUSY, r);
         end else begin
            // Busy, or an unknown code taken as busy. The exponent is capped
            // at the ceiling, which can lower it.
            nb = {1'b0, busy_count} + 4'd1;
            be = {1'b0, cur_exp} + 5'd1;
            if (be > {1'b0, cfg.max_backoff_exp}) be = {1'b0, cfg.max_backoff_exp};
            cur_exp    = be[3:0];
            busy_count = nb[2:0];
            if (nb > {1'b0, cfg.max_backoffs}) begin
               close_transfer(ST_CH_BUSY, r);
            end else begin
               r.action     = ACT_BACKOFF;
               r.backoff_us = backoff_delay(ev.rand_value);
            end
         end
      end else if (ev.req_type == REQ_TX_RESULT && tx_phase == PH_TX) begin
         if (ev.tx_status == TX_OK) begin
            close_transfer(ST_OK, r);
         end else if (ev.tx_status == TX_NO_ACK) begin
            if (want_ack) begin
               nr      = {1'b0, retries} + 5'd1;
               retries = (nr > 5'd15) ? 4'd15 : nr[3:0];
               if (nr < {1'b0, cfg.max_transmissions}) start_attempt(ev.rand_value, r);
               else close_transfer(ST_NO_ACK, r);
            end else begin
               close_transfer(ST_NO_ACK, r);
            end
         end else begin
            close_transfer(ST_TX_ERROR, r);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic add_row(input logic [1:0] kind, input logic ack, input logic [7:0] rnd,
                          input logic [1:0] cca, input logic [1:0] txs, input logic typed,
                          input action_type act, input logic [23:0] delay,
                          input status_type st, input logic [3:0] rtr);
      event_row_type row;
      row.ev.req_type         = kind;
      row.ev.ack_request      = ack;
      row.ev.rand_value       = rnd;
      row.ev.cca_status       = cca;
      row.ev.tx_status        = txs;
      row.typed               = typed;
      row.rsp.action          = act;
      row.rsp.backoff_us      = delay;
      row.rsp.final_status    = st;
      row.rsp.retries_used    = rtr;
      directed_rows.push_back(row);
   endtask

   // Presents one event, waits for it to be taken and records what should
   // come back. The gap before it idles the request side at random; tvalid
   // is only lowered here and in wait_drained, so it never gets two assignments in one step.
   task automatic send_event(input req_item_type ev, input logic typed,
                             input rsp_item_type typed_rsp);
      rsp_item_type predicted;
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev.req_type;
      req_tdata  <= {3'b000, ev.tx_status, ev.cca_status, ev.rand_value, ev.ack_request};
      do @(posedge clock); while (!req_tready);
      predict_response(ev, predicted);
      pending_responses.push_back(typed ? typed_rsp : predicted);
      events_sent++;
      if (predicted.action == ACT_DONE) status_count[predicted.final_status]++;
   endtask

   // Random event. Most follow the phase the transfer is in, so that
   // transfers run deep into retries and backoffs; the rest are noise.
   task automatic make_event(output req_item_type ev);
      int roll;
      ev.req_type     = 2'($urandom_range(0, 3));
      ev.ack_request  = 1'($urandom_range(0, 1));
      ev.rand_value   = 8'($urandom_range(0, 255));
      ev.cca_status   = 2'($urandom_range(0, 3));
      ev.tx_status    = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) begin
         case (tx_phase)
            PH_IDLE: begin
               ev.req_type     = REQ_START;
               ev.ack_request  = ($urandom_range(0, 99) < 75);
            end
            PH_CCA: begin
               ev.req_type   = REQ_CCA;
               ev.cca_status = (roll < 50) ? CCA_FREE :
                               (roll < 85) ? CCA_BUSY :
                               (roll < 93) ? CCA_RX_BUSY : CCA_UNKNOWN;
            end
            default: begin
               ev.req_type  = REQ_TX_RESULT;
               ev.tx_status = (roll < 45) ? TX_NO_ACK :
                              (roll < 75) ? TX_OK :
                              (roll < 90) ? TX_ERROR : TX_UNKNOWN;
            end
         endcase
      end
   endtask

   // Register write; csr_valid stays high so that writes can follow back to
   // back, and the caller lowers it after the last one.
   task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MIN_BACKOFF_EXP:   cfg.min_backoff_exp   = val[3:0];
         CSR_MAX_BACKOFF_EXP:   cfg.max_backoff_exp   = val[3:0];
         CSR_MAX_BACKOFFS:      cfg.max_backoffs      = val[2:0];
         CSR_MAX_TRANSMISSIONS: cfg.max_transmissions = val[3:0];
         CSR_UNIT_BACKOFF_US:   cfg.unit_backoff_us   = val;
         default: ;
      endcase
   endtask

   // Stops driving requests and waits until every result item has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic report(input string field, input int want, input int got);
      mismatches++;
      if (prints < PRINT_LIMIT) begin
         prints++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   // The receiver stalls at random, except in the calm stretch.
   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Each result item taken is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_responses.size() == 0) begin
            report("result item with nothing expected, action", -1, rsp_tuser);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tuser != want.action)
               report("action", want.action, rsp_tuser);
            if (rsp_tdata[23:0] != want.backoff_us)
               report("backoff_us", want.backoff_us, rsp_tdata[23:0]);
            if (rsp_tdata[26:24] != want.final_status)
               report("final_status", want.final_status, rsp_tdata[26:24]);
            if (rsp_tdata[30:27] != want.retries_used)
               report("retries_used", want.retries_used, rsp_tdata[30:27]);
         end
      end
   end

   // Watchdog: ends the run when no item has moved on any channel for too
   // long. Random gaps and stalls are short, so this only trips on a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, pending_responses.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      req_item_type ev;
      rsp_item_type none_rsp;
      cfg_type      setting;
      int           target;

      none_rsp = '0;

      // State after reset: the default limits and an idle transfer.
      cfg.min_backoff_exp   = MinBackoffExpReset;
      cfg.max_backoff_exp   = MaxBackoffExpReset;
      cfg.max_backoffs      = MaxBackoffsReset;
      cfg.max_transmissions = MaxTransmissionsReset;
      cfg.unit_backoff_us   = UnitBackoffUsReset;
      tx_phase   = PH_IDLE;
      busy_count = '0;
      cur_exp    = '0;
      retries    = '0;
      want_ack   = 1'b0;

      // Directed part, at the default limits: exponent 3 rising to 5, four
      // busy CCAs allowed, three transmissions, 320 us per unit.
      // Out of phase events and the reserved kind do nothing.
      add_row(REQ_CCA,       1'b0, 8'h00, CCA_FREE, TX_OK, 1'b1, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_RESERVED,  1'b1, 8'hFF, CCA_UNKNOWN, TX_UNKNOWN, 1'b1,
              ACT_NONE, 24'd0, ST_OK, 4'd0);
      // Start with the largest random byte: seven units at exponent 3.
      add_row(REQ_START,     1'b1, 8'hFF, CCA_FREE, TX_OK, 1'b1,
              ACT_BACKOFF, 24'd2240, ST_OK, 4'd0);
      add_row(REQ_START,     1'b1, 8'hFF, CCA_FREE, TX_OK, 1'b1, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_TX_RESULT, 1'b1, 8'hFF, CCA_FREE, TX_OK, 1'b1, ACT_NONE, 24'd0, ST_OK, 4'd0);
      // Busy channel, including the unknown code, until the exponent sits at
      // its ceiling and the backoff limit is passed.
      add_row(REQ_CCA, 1'b0, 8'hFF, CCA_BUSY,    TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA, 1'b0, 8'hFF, CCA_UNKNOWN, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA, 1'b0, 8'h55, CCA_BUSY,    TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA, 1'b0, 8'hFF, CCA_BUSY,    TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA, 1'b0, 8'hFF, CCA_BUSY,    TX_OK, 1'b1,
              ACT_DONE, 24'd0, ST_CH_BUSY, 4'd0);
      // Missing acks on an ack-requested frame, up to the transmission limit.
      add_row(REQ_START, 1'b1, 8'h00, CCA_FREE, TX_OK, 1'b1, ACT_BACKOFF, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA,   1'b0, 8'h00, CCA_FREE, TX_OK, 1'b1, ACT_SEND, 24'd0, ST_OK, 4'd0);
      add_row(REQ_TX_RESULT, 1'b0, 8'hAA, CCA_FREE, TX_NO_ACK, 1'b0,
              ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA,   1'b0, 8'h00, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_TX_RESULT, 1'b0, 8'h81, CCA_FREE, TX_NO_ACK, 1'b0,
              ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA,   1'b0, 8'h00, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_TX_RESULT, 1'b0, 8'h00, CCA_FREE, TX_NO_ACK, 1'b1,
              ACT_DONE, 24'd0, ST_NO_ACK, 4'd3);
      // No ack on a frame that asked for none finishes without a retry.
      add_row(REQ_START, 1'b0, 8'h0F, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA,   1'b0, 8'h00, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_TX_RESULT, 1'b0, 8'h00, CCA_FREE, TX_NO_ACK, 1'b1,
              ACT_DONE, 24'd0, ST_NO_ACK, 4'd0);
      // Radio busy receiving during CCA.
      add_row(REQ_START, 1'b1, 8'h3C, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA,   1'b0, 8'h00, CCA_RX_BUSY, TX_OK, 1'b1,
              ACT_DONE, 24'd0, ST_RADIO_BUSY, 4'd0);
      // Clean transfer, then an unknown transmit code taken as a radio error.
      add_row(REQ_START, 1'b1, 8'hC3, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA,   1'b0, 8'h00, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_TX_RESULT, 1'b0, 8'h00, CCA_FREE, TX_OK, 1'b1, ACT_DONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_START, 1'b0, 8'h7E, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_CCA,   1'b0, 8'h00, CCA_FREE, TX_OK, 1'b0, ACT_NONE, 24'd0, ST_OK, 4'd0);
      add_row(REQ_TX_RESULT, 1'b0, 8'h00, CCA_FREE, TX_UNKNOWN, 1'b1,
              ACT_DONE, 24'd0, ST_TX_ERROR, 4'd0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].rsp);

      // Random part, in phases with a different register setting each. The
      // registers are only written once every result item is back and a
      // short pause has passed.
      for (int p = 0; p < SETTING_PHASES; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         case (p)
            0: setting = '{4'd0,  4'd0,  3'd0, 4'd1,  16'd1};
            1: setting = '{4'd8,  4'd8,  3'd5, 4'd15, 16'hFFFF};
            // Exponent above the ceiling, large exponents, zero transmission
            // limit and a zero unit period, all beyond the usual ranges.
            2: setting = '{4'd15, 4'd2,  3'd7, 4'd0,  16'd0};
            3: setting = '{MinBackoffExpReset, MaxBackoffExpReset, MaxBackoffsReset,
                           MaxTransmissionsReset, UnitBackoffUsReset};
            6: setting = '{4'd2,  4'd15, 3'd1, 4'd2,  16'd1000};
            default: setting = '{4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                 16'($urandom_range(0, 65535))};
         endcase
         write_register(CSR_MIN_BACKOFF_EXP,   {12'd0, setting.min_backoff_exp});
         write_register(CSR_MAX_BACKOFF_EXP,   {12'd0, setting.max_backoff_exp});
         write_register(CSR_MAX_BACKOFFS,      {13'd0, setting.max_backoffs});
         write_register(CSR_MAX_TRANSMISSIONS, {12'd0, setting.max_transmissions});
         write_register(CSR_UNIT_BACKOFF_US,   setting.unit_backoff_us);
         // An index past the last register is taken and ignored.
         write_register(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                        16'($urandom_range(0, 65535)));
         csr_valid <= 1'b0;

         calm = (p == 3);
         target = events_sent + RANDOM_ITEMS / SETTING_PHASES;
         while (events_sent < target) begin
            make_event(ev);
            send_event(ev, 1'b0, none_rsp);
         end
         calm = 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d events sent (%0d directed), %0d result items checked, %0d settings",
               events_sent, directed_rows.size(), results_seen, SETTING_PHASES);
      $display("finished transfers: ok %0d, no ack %0d, channel busy %0d, radio busy %0d, %s %0d",
               status_count[ST_OK], status_count[ST_NO_ACK], status_count[ST_CH_BUSY],
               status_count[ST_RADIO_BUSY], "tx error", status_count[ST_TX_ERROR]);
      if (mismatches == 0 && pending_responses.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: files.f
design/csmatx_pkg.sv
design/csmatx_csr.sv
design/csmatx_fsm.sv
design/csma_ca_transmit_controller.sv
test/csma_ca_transmit_controller_tb.sv
